[rtl/sgm_pkg.sv]
// Shared constants and types for the Sobel gradient magnitude block.
`default_nettype none

package sgm_pkg;

   localparam int TAP_COUNT           = 9;
   localparam int TAP_WIDTH           = 16;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int MAG_WIDTH           = 16;
   localparam int REQ_TDATA_WIDTH     = 160;
   localparam int RSP_TDATA_WIDTH     = 24;
   localparam int PRESENT_LSB         = TAP_COUNT * TAP_WIDTH;
   localparam int EDGE_BIT            = MAG_WIDTH;

   localparam logic [MAG_WIDTH-1:0] MAX_VALUE_RESET = MAG_WIDTH'(255);

   localparam int TAP_TL = 0;
   localparam int TAP_TM = 1;
   localparam int TAP_TR = 2;
   localparam int TAP_ML = 3;
   localparam int TAP_MR = 5;
   localparam int TAP_BL = 6;
   localparam int TAP_BM = 7;
   localparam int TAP_BR = 8;

   typedef logic [TAP_COUNT-1:0][TAP_WIDTH-1:0] tap_vec_type;
   typedef logic [TAP_COUNT-1:0] present_type;

endpackage

`default_nettype wire

[rtl/sgm_grad.sv]
// Sobel sums, absolute gradients, squares and their sum in four pipeline stages.
`default_nettype none

module sgm_grad
   import sgm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int PART_BITS  = SAMPLE_BITS + 2,
   localparam int SQ_BITS    = 2 * PART_BITS,
   localparam int SUM_BITS   = SQ_BITS + 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire tap_vec_type         in_taps,
   input  wire present_type         in_present,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [SUM_BITS-1:0]      out_sum
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff;
   wire  [STAGES:0]   stage_ready;

   logic [SAMPLE_BITS-1:0] sample [TAP_COUNT];

   logic [PART_BITS-1:0] x_pos_ff, x_neg_ff, y_pos_ff, y_neg_ff;
   logic [PART_BITS-1:0] x_pos_in, x_neg_in, y_pos_in, y_neg_in;
   logic [PART_BITS-1:0] abs_x_ff, abs_y_ff, abs_x_in, abs_y_in;
   logic [SQ_BITS-1:0]   sq_x_ff, sq_y_ff;
   logic [SUM_BITS-1:0]  sum_ff;

   assign stage_ready[STAGES] = out_ready;

   for (genvar k = 0; k < STAGES; k++) begin : g_ready
      assign stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
   end

   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         sample[i] = in_present[i] ? in_taps[i][SAMPLE_BITS-1:0] : '0;
      end
      x_pos_in = PART_BITS'(sample[TAP_TR]) + (PART_BITS'(sample[TAP_MR]) << 1)
               + PART_BITS'(sample[TAP_BR]);
      x_neg_in = PART_BITS'(sample[TAP_TL]) + (PART_BITS'(sample[TAP_ML]) << 1)
               + PART_BITS'(sample[TAP_BL]);
      y_pos_in = PART_BITS'(sample[TAP_BL]) + (PART_BITS'(sample[TAP_BM]) << 1)
               + PART_BITS'(sample[TAP_BR]);
      y_neg_in = PART_BITS'(sample[TAP_TL]) + (PART_BITS'(sample[TAP_TM]) << 1)
               + PART_BITS'(sample[TAP_TR]);
      abs_x_in = (x_pos_ff >= x_neg_ff) ? x_pos_ff - x_neg_ff : x_neg_ff - x_pos_ff;
      abs_y_in = (y_pos_ff >= y_neg_ff) ? y_pos_ff - y_neg_ff : y_neg_ff - y_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (stage_ready[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         x_pos_ff <= x_pos_in;
         x_neg_ff <= x_neg_in;
         y_pos_ff <= y_pos_in;
         y_neg_ff <= y_neg_in;
      end
      if (stage_ready[1]) begin
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
      end
      if (stage_ready[2]) begin
         sq_x_ff <= abs_x_ff * abs_x_ff;
         sq_y_ff <= abs_y_ff * abs_y_ff;
      end
      if (stage_ready[3]) begin
         sum_ff <= SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff);
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_sum   = sum_ff;

endmodule

`default_nettype wire

[rtl/sgm_sqrt.sv]
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module sgm_sqrt
   import sgm_pkg::*;
#(
   parameter int RADICAND_BITS = 2 * (SAMPLE_BITS_DEFAULT + 2) + 1,
   localparam int ROOT_BITS    = (RADICAND_BITS + 1) / 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [RADICAND_BITS-1:0] in_radicand,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [ROOT_BITS-1:0]          out_root
);

   localparam int STAGES   = ROOT_BITS;
   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int WIDE     = ROOT_BITS + 4;

   logic [STAGES-1:0]   valid_ff;
   logic [REM_BITS-1:0] rem_ff  [STAGES];
   logic [ROOT_BITS-1:0] root_ff [STAGES];
   logic [RAD_BITS-1:0] rad_ff  [STAGES];

   wire  [STAGES:0]     stage_ready;
   wire  [STAGES-1:0]   prev_valid;
   wire  [REM_BITS-1:0] prev_rem  [STAGES];
   wire  [ROOT_BITS-1:0] prev_root [STAGES];
   wire  [RAD_BITS-1:0] prev_rad  [STAGES];
   wire  [REM_BITS-1:0] next_rem  [STAGES];
   wire  [ROOT_BITS-1:0] next_root [STAGES];
   wire  [RAD_BITS-1:0] next_rad  [STAGES];

   assign stage_ready[STAGES] = out_ready;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      wire [WIDE-1:0] shifted;
      wire [WIDE-1:0] trial;
      wire [WIDE-1:0] diff;
      wire            take;

      if (k == 0) begin : g_first
         assign prev_valid[k] = in_valid;
         assign prev_rem[k]   = '0;
         assign prev_root[k]  = '0;
         assign prev_rad[k]   = RAD_BITS'(in_radicand);
      end else begin : g_rest
         assign prev_valid[k] = valid_ff[k-1];
         assign prev_rem[k]   = rem_ff[k-1];
         assign prev_root[k]  = root_ff[k-1];
         assign prev_rad[k]   = rad_ff[k-1];
      end

      assign stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      assign shifted = {prev_rem[k], prev_rad[k][RAD_BITS-1 -: 2]};
      assign trial   = {2'b00, prev_root[k], 2'b01};
      assign diff    = shifted - trial;
      assign take    = shifted >= trial;
      assign next_rem[k]  = take ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
      assign next_root[k] = {prev_root[k][ROOT_BITS-2:0], take};
      assign next_rad[k]  = {prev_rad[k][RAD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_ready[k]) valid_ff[k] <= prev_valid[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (stage_ready[k]) begin
            rem_ff[k]  <= next_rem[k];
            root_ff[k] <= next_root[k];
            rad_ff[k]  <= next_rad[k];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];

endmodule

`default_nettype wire

[rtl/sobel_gradient_magnitude.sv]
// Sobel gradient magnitude of one 3x3 channel window, clamped, with edge flag.
// The pipeline is four gradient stages, one square root stage per result bit
// (SAMPLE_BITS + 3), and the output register. Throughput is one beat per cycle
// unless rsp_tready stalls it; every stage has its own valid bit and ready.
// Reset empties the pipeline and sets max_value to 255; configuration is taken at once.
`default_nettype none

module sobel_gradient_magnitude
   import sgm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Nine taps row-major, 16 bits each from bit 0, then tap_present, zero fill.
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // magnitude in bits 15:0, edge_flag in bit 16, zero fill.
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire logic [MAG_WIDTH-1:0]       csr_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready
);

   localparam int SUM_BITS  = 2 * (SAMPLE_BITS + 2) + 1;
   localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
   localparam int CMP_BITS  = (ROOT_BITS > MAG_WIDTH) ? ROOT_BITS : MAG_WIDTH;

   logic [MAG_WIDTH-1:0] max_value_ff;
   logic [MAG_WIDTH-1:0] mag_ff, mag_in;
   logic                 edge_ff, edge_in;
   logic                 rsp_valid_ff;

   tap_vec_type          taps;
   present_type          present;
   logic                 grad_valid, grad_ready;
   logic [SUM_BITS-1:0]  grad_sum;
   logic                 root_valid, root_ready;
   logic [ROOT_BITS-1:0] root;

   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         taps[i] = req_tdata[i*TAP_WIDTH +: TAP_WIDTH];
      end
      present = req_tdata[PRESENT_LSB +: TAP_COUNT];
   end

   sgm_grad #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_grad (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_taps    (taps),
      .in_present (present),
      .out_valid  (grad_valid),
      .out_ready  (grad_ready),
      .out_sum    (grad_sum)
   );

   sgm_sqrt #(
      .RADICAND_BITS(SUM_BITS)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (grad_valid),
      .in_ready    (grad_ready),
      .in_radicand (grad_sum),
      .out_valid   (root_valid),
      .out_ready   (root_ready),
      .out_root    (root)
   );

   assign root_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (CMP_BITS'(root) >= CMP_BITS'(max_value_ff)) begin
         mag_in = max_value_ff;
      end else begin
         mag_in = MAG_WIDTH'(root);
      end
      edge_in = mag_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_value_ff <= MAX_VALUE_RESET;
      end else begin
         if (root_ready) rsp_valid_ff <= root_valid;
         if (csr_valid) max_value_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (root_ready) begin
         mag_ff  <= mag_in;
         edge_ff <= edge_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_WIDTH - MAG_WIDTH - 1)'(0), edge_ff, mag_ff};

endmodule

`default_nettype wire

[rtl/sgm_checker.sv]
// Port-level checks for the Sobel gradient magnitude block, bound to the top level.
`default_nettype none

module sgm_checker
   import sgm_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [MAG_WIDTH-1:0]       csr_data,
   input wire logic                       csr_valid,
   input wire logic                       csr_ready
);

   logic [MAG_WIDTH-1:0] max_shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_shadow_ff <= MAX_VALUE_RESET;
      end else if (csr_valid && csr_ready) begin
         max_shadow_ff <= csr_data;
      end
   end

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("Stalled request beat changed.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response beat changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid right after reset.");

   a_edge_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[EDGE_BIT] == (rsp_tdata[MAG_WIDTH-1:0] != '0))
      else $error("Edge flag does not match magnitude.");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[MAG_WIDTH-1:0] <= max_shadow_ff)
      else $error("Magnitude above the configured maximum.");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (.*);

`default_nettype wire

[bench/sgm_checker.sv]
// Checker that predicts and compares Sobel gradient magnitude results beat by beat.
module sgm_result_checker
   import sgm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tready,
   input  wire logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  wire logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire logic [MAG_WIDTH-1:0]       csr_data,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   output int                              error_count,
   output int                              pending_count,
   output int                              checked_count,
   output int                              clamped_count,
   output int                              flat_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SAMPLE_MASK = (longint'(1) << SAMPLE_BITS) - 1;

   typedef struct packed {
      logic                 edge_flag;
      logic [MAG_WIDTH-1:0] magnitude;
   } grad_result_type;

   grad_result_type      expected_magnitudes[$];
   logic [MAG_WIDTH-1:0] max_value;

   function automatic longint floor_root(longint square);
      longint root = 0;
      longint trial;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= square) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic grad_result_type sobel_magnitude(tap_vec_type taps,
                                                       present_type present,
                                                       logic [MAG_WIDTH-1:0] limit,
                                                       output bit hit_limit);
      longint          gx = 0;
      longint          gy = 0;
      longint          s;
      longint          mag;
      grad_result_type res;
      for (int i = 0; i < TAP_COUNT; i++) begin
         if (present[i]) begin
            s = longint'(taps[i]) & SAMPLE_MASK;
            case (i)
               TAP_TL: begin gx -= s;     gy -= s;     end
               TAP_TM: begin              gy -= 2 * s; end
               TAP_TR: begin gx += s;     gy -= s;     end
               TAP_ML: begin gx -= 2 * s;              end
               TAP_MR: begin gx += 2 * s;              end
               TAP_BL: begin gx -= s;     gy += s;     end
               TAP_BM: begin              gy += 2 * s; end
               TAP_BR: begin gx += s;     gy += s;     end
               default: begin end
            endcase
         end
      end
      mag = floor_root(gx * gx + gy * gy);
      hit_limit = (mag > longint'(limit));
      if (mag >= longint'(limit)) begin
         mag = longint'(limit);
      end
      res.magnitude = mag[MAG_WIDTH-1:0];
      res.edge_flag = (mag != 0);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
      clamped_count = 0;
      flat_count    = 0;
      max_value     = MAX_VALUE_RESET;
   end

   always @(posedge clock) begin
      grad_result_type want;
      bit              hit_limit;
      if (reset) begin
         max_value = MAX_VALUE_RESET;
         expected_magnitudes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            max_value = csr_data;
         end
         if (req_tvalid && req_tready) begin
            want = sobel_magnitude(tap_vec_type'(req_tdata[PRESENT_LSB-1:0]),
                                   req_tdata[PRESENT_LSB +: TAP_COUNT], max_value, hit_limit);
            expected_magnitudes.push_back(want);
            if (hit_limit) begin
               clamped_count++;
            end
            if (!want.edge_flag) begin
               flat_count++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_magnitudes.size() == 0) begin
               report_mismatch("unexpected result beat, magnitude", -1,
                               rsp_tdata[MAG_WIDTH-1:0]);
            end else begin
               want = expected_magnitudes.pop_front();
               checked_count++;
               if (rsp_tdata[MAG_WIDTH-1:0] !== want.magnitude) begin
                  report_mismatch("magnitude", want.magnitude, rsp_tdata[MAG_WIDTH-1:0]);
               end
               if (rsp_tdata[EDGE_BIT] !== want.edge_flag) begin
                  report_mismatch("edge_flag", want.edge_flag, rsp_tdata[EDGE_BIT]);
               end
            end
         end
      end
      pending_count = expected_magnitudes.size();
   end

endmodule

[bench/sobel_gradient_magnitude_tb.sv]
// Testbench top that drives Sobel windows and settings and reports the verdict.
module sobel_gradient_magnitude_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sgm_pkg::*;

   localparam int          DIRECTED_COUNT  = 20;
   localparam int          ITEMS_PER_PHASE = 210;
   localparam int          PHASE_COUNT     = 9;
   localparam int          IDLE_LIMIT      = 3000;
   localparam present_type ROW_TOP         = 9'b000_000_111;
   localparam present_type ROW_BOTTOM      = 9'b111_000_000;
   localparam present_type COL_LEFT        = 9'b001_001_001;
   localparam present_type COL_RIGHT       = 9'b100_100_100;

   logic                       clock;
   logic                       reset;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [MAG_WIDTH-1:0]       csr_data;
   logic                       csr_valid;
   logic                       csr_ready;

   int error_count;
   int pending_count;
   int checked_count;
   int clamped_count;
   int flat_count;
   int windows_sent;
   int settings_written;
   bit send_idle_on;
   bit rsp_idle_on;
   bit rsp_long_hold;

   sobel_gradient_magnitude uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   sgm_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_data      (csr_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .clamped_count (clamped_count),
      .flat_count    (flat_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void directed_window(int k, output tap_vec_type taps,
                                           output present_type present);
      taps    = '0;
      present = '1;
      case (k)
         1: taps = '1;
         2: begin taps[TAP_TR] = '1; taps[TAP_MR] = '1; taps[TAP_BR] = '1; end
         3: begin taps[TAP_TL] = '1; taps[TAP_TM] = '1; taps[TAP_TR] = '1; end
         4: begin
            taps[TAP_TR] = '1; taps[TAP_MR] = '1; taps[TAP_BR] = '1;
            taps[TAP_BM] = '1; taps[TAP_BL] = '1;
         end
         5: begin taps = '1; present = '0; end
         6: begin taps = {TAP_COUNT{16'd1000}}; present = ~COL_LEFT; end
         7: begin taps = {TAP_COUNT{16'd1000}}; present = ~COL_RIGHT; end
         8: begin taps = {TAP_COUNT{16'd1000}}; present = ~ROW_TOP; end
         9: begin taps = {TAP_COUNT{16'd1000}}; present = ~ROW_BOTTOM; end
         10: begin taps = '1; present = ~(ROW_TOP | COL_LEFT); end
         11: begin taps = '1; present = ~(ROW_BOTTOM | COL_RIGHT); end
         12: taps[4] = '1;
         13: taps[TAP_TR] = 16'd1;
         14: taps[TAP_MR] = 16'd1;
         15: for (int i = 0; i < TAP_COUNT; i++) taps[i] = i[0] ? 16'hAAAA : 16'h5555;
         16: begin
            taps[TAP_TL] = 16'h8000; taps[TAP_ML] = 16'h8000; taps[TAP_BL] = 16'h8000;
            taps[TAP_TR] = 16'h7FFF; taps[TAP_MR] = 16'h7FFF; taps[TAP_BR] = 16'h7FFF;
         end
         17: begin taps = '1; present = '0; present[TAP_BM] = 1'b1; end
         18: for (int i = 0; i < TAP_COUNT; i++) taps[i] = 16'(i * 7000);
         19: for (int i = 0; i < TAP_COUNT; i++) taps[i] = 16'(65535 - i * 8000);
         default: begin end
      endcase
   endfunction

   function automatic void random_window(output tap_vec_type taps, output present_type present);
      int                   kind;
      int                   spread;
      logic [TAP_WIDTH-1:0] base;
      kind   = $urandom_range(0, 9);
      base   = TAP_WIDTH'($urandom);
      spread = $urandom_range(0, 12);
      for (int i = 0; i < TAP_COUNT; i++) begin
         if (kind < 3) begin
            taps[i] = TAP_WIDTH'($urandom);
         end else if (kind < 5) begin
            taps[i] = $urandom_range(0, 1) ? '1 : '0;
         end else begin
            taps[i] = base + TAP_WIDTH'($urandom & ((1 << spread) - 1));
         end
      end
      if ($urandom_range(0, 9) < 6) begin
         present = '1;
      end else begin
         case ($urandom_range(0, 8))
            0: present = ~ROW_TOP;
            1: present = ~ROW_BOTTOM;
            2: present = ~COL_LEFT;
            3: present = ~COL_RIGHT;
            4: present = ~(ROW_TOP | COL_LEFT);
            5: present = ~(ROW_TOP | COL_RIGHT);
            6: present = ~(ROW_BOTTOM | COL_LEFT);
            7: present = ~(ROW_BOTTOM | COL_RIGHT);
            default: present = TAP_COUNT'($urandom);
         endcase
      end
   endfunction

   task automatic send_window(tap_vec_type taps, present_type present, int gap);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = REQ_TDATA_WIDTH'({present, taps});
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      windows_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_max_value(logic [MAG_WIDTH-1:0] value);
      wait_drained();
      repeat (30) @(negedge clock);
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      settings_written++;
   endtask

   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_long_hold) begin
            n             = 300;
            rsp_long_hold = 1'b0;
         end else begin
            n = rsp_idle_on ? $urandom_range(0, 13) : 0;
         end
         if (n > 0) begin
            rsp_tready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      int idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Timeout: no beat accepted for %0d cycles", idle_cycles);
      $display("Verification failed");
      $finish;
   end

   initial begin
      tap_vec_type          taps;
      present_type          present;
      int                   gap;
      logic [MAG_WIDTH-1:0] limits [1:PHASE_COUNT-1];
      limits[1]        = 16'hFFFF;
      limits[2]        = 16'd0;
      limits[3]        = 16'd1;
      limits[4]        = MAG_WIDTH'($urandom);
      limits[5]        = 16'd1023;
      limits[6]        = MAG_WIDTH'($urandom_range(2, 600));
      limits[7]        = 16'd255;
      limits[8]        = 16'hFFFF;
      reset            = 1'b1;
      req_tdata        = '0;
      req_tvalid       = 1'b0;
      csr_data         = '0;
      csr_valid        = 1'b0;
      windows_sent     = 0;
      settings_written = 0;
      send_idle_on     = 1'b1;
      rsp_idle_on      = 1'b1;
      rsp_long_hold    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            write_max_value(limits[phase]);
         end
         if (phase == 0) begin
            for (int k = 0; k < DIRECTED_COUNT; k++) begin
               directed_window(k, taps, present);
               send_window(taps, present, $urandom_range(0, 13));
            end
         end
         if (phase == 1) begin
            rsp_long_hold = 1'b1;
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 50 == 0) begin
               send_idle_on = ($urandom_range(0, 3) != 0);
               rsp_idle_on  = ($urandom_range(0, 3) != 0);
            end
            if (phase == 4 && i == 105) begin
               wait_drained();
            end
            random_window(taps, present);
            gap = (send_idle_on && !(phase == 1 && i < 120)) ? $urandom_range(0, 13) : 0;
            send_window(taps, present, gap);
         end
      end

      wait_drained();
      repeat (40) @(negedge clock);
      $display("Run covered %0d windows and %0d checked results over %0d max_value writes.",
               windows_sent, checked_count, settings_written);
      $display("%0d results were clamped and %0d came out with a clear edge flag.",
               clamped_count, flat_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sobel_gradient_magnitude.f]
rtl/sgm_pkg.sv
rtl/sgm_grad.sv
rtl/sgm_sqrt.sv
rtl/sobel_gradient_magnitude.sv
rtl/sgm_checker.sv
bench/sgm_checker.sv
bench/sobel_gradient_magnitude_tb.sv
